### src/lmps_pkg.sv
// Shared types, codes and constants for the LED matrix pixel store.
package lmps_pkg;

	localparam int NUM_PIXELS_DEF = 256;

	localparam int COORD_W = 8;
	localparam int COLOR_W = 24;
	localparam int DIM_W   = 7;
	localparam int ORIENT_W = 3;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// Coordinate math width: holds -128..254 with sign.
	localparam int CALC_W = 10;
	// Strip index width: product of CALC_W by DIM_W+1 signed.
	localparam int IDX_W  = 18;

	localparam logic [DIM_W-1:0]    WIDTH_RST  = 7'd16;
	localparam logic [DIM_W-1:0]    LENGTH_RST = 7'd16;
	localparam logic [ORIENT_W-1:0] ORIENT_RST = 3'd0;
	localparam logic                ZIGZAG_RST = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLIP = 2'd0,
		MODE_WRAP = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_LENGTH = 2'd1,
		CFG_ORIENT = 2'd2,
		CFG_ZIGZAG = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic orient;
		logic mult;
		logic addr;
		logic mem_go;
		logic load_out;
	} lmps_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic item_read;
	} lmps_status_t;

endpackage

### src/lmps_ctrl.sv
// Sequencer for the LED matrix pixel store: clearing pass and per-transfer steps.
module lmps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  lmps_pkg::lmps_status_t status,
	output lmps_pkg::lmps_cmd_t   cmd
);
	import lmps_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ORIENT,
		ST_MULT,
		ST_ADDR,
		ST_MEM,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clr_step  = 1'b1;
			ST_IDLE:   cmd.load_item = in_valid;
			ST_ORIENT: cmd.orient    = 1'b1;
			ST_MULT:   cmd.mult      = 1'b1;
			ST_ADDR:   cmd.addr      = 1'b1;
			ST_MEM:    cmd.mem_go    = 1'b1;
			ST_RESP:   cmd.load_out  = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// new result loads as the old one leaves; otherwise clear on transfer
			if (state_q == ST_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_ORIENT;
				end
				ST_ORIENT: state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_ADDR;
				ST_ADDR:   state_q <= ST_MEM;
				ST_MEM: begin
					state_q <= status.item_read ? ST_RESP : ST_IDLE;
				end
				ST_RESP: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/lmps_dpath.sv
// Datapath: config registers, coordinate wrap/orientation, strip index, pixel memory.
module lmps_dpath #(
	parameter int NUM_PIXELS = lmps_pkg::NUM_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmps_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	input  logic [lmps_pkg::MODE_W-1:0]         mode,
	input  logic signed [lmps_pkg::COORD_W-1:0] x_coord,
	input  logic signed [lmps_pkg::COORD_W-1:0] y_coord,
	input  logic [lmps_pkg::COLOR_W-1:0]        pixel_color,
	output logic [lmps_pkg::COLOR_W-1:0]        read_color,
	input  lmps_pkg::lmps_cmd_t                 cmd,
	output lmps_pkg::lmps_status_t              status
);
	import lmps_pkg::*;

	localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

	// configuration
	logic [DIM_W-1:0]    grid_width_q;
	logic [DIM_W-1:0]    grid_length_q;
	logic [ORIENT_W-1:0] orientation_q;
	logic                zigzag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_RST;
			grid_length_q <= LENGTH_RST;
			orientation_q <= ORIENT_RST;
			zigzag_q      <= ZIGZAG_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  grid_width_q  <= cfg_wr_data[DIM_W-1:0];
				CFG_LENGTH: grid_length_q <= cfg_wr_data[DIM_W-1:0];
				CFG_ORIENT: orientation_q <= cfg_wr_data[ORIENT_W-1:0];
				CFG_ZIGZAG: zigzag_q      <= cfg_wr_data[0];
				default: ;
			endcase
		end
	end

	logic signed [CALC_W-1:0] w_s, l_s;
	assign w_s = signed'({{(CALC_W-DIM_W){1'b0}}, grid_width_q});
	assign l_s = signed'({{(CALC_W-DIM_W){1'b0}}, grid_length_q});

	// stage 1: capture, wrap by one period, grid clip for writes
	logic signed [CALC_W-1:0] xr, yr, xa, ya, xb, yb, xn, yn;
	logic                     is_wrap, is_write, on_grid;

	always_comb begin
		xr = CALC_W'(x_coord);
		yr = CALC_W'(y_coord);
		xa = (xr < 0) ? xr + w_s : xr;
		ya = (yr < 0) ? yr + l_s : yr;
		xb = (xa >= w_s) ? xa - w_s : xa;
		yb = (ya >= l_s) ? ya - l_s : ya;
		is_wrap  = (mode == MODE_WRAP);
		is_write = (mode == MODE_CLIP) || is_wrap;
		xn = is_wrap ? xb : xr;
		yn = is_wrap ? yb : yr;
		on_grid = (xn >= 0) && (xn < w_s) && (yn >= 0) && (yn < l_s);
	end

	logic signed [CALC_W-1:0] x_s1, y_s1;
	logic [COLOR_W-1:0]       color_s1;
	logic                     wr_s1, rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rd_s1 <= 1'b0;
		end else if (cmd.load_item) begin
			wr_s1 <= is_write && on_grid;
			rd_s1 <= (mode == MODE_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_s1     <= xn;
			y_s1     <= yn;
			color_s1 <= pixel_color;
		end
	end

	// stage 2: orientation (mirror, then swap on odd codes)
	logic signed [CALC_W-1:0] xm, ym;
	logic signed [CALC_W-1:0] px_s2, py_s2;
	logic [DIM_W-1:0]         m_s2;
	logic                     flip_s2;

	assign xm = orientation_q[2] ? (w_s - x_s1 - CALC_W'(1)) : x_s1;
	assign ym = (orientation_q[2] ^ orientation_q[1]) ? (l_s - y_s1 - CALC_W'(1)) : y_s1;

	always_ff @(posedge clk) begin
		if (cmd.orient) begin
			px_s2   <= orientation_q[0] ? ym : xm;
			py_s2   <= orientation_q[0] ? xm : ym;
			m_s2    <= orientation_q[0] ? grid_length_q : grid_width_q;
			flip_s2 <= zigzag_q && (orientation_q[0] ? xm[0] : ym[0]);
		end
	end

	// stage 3: row product and serpentine column offset
	logic signed [DIM_W:0]    m_sx;
	logic signed [IDX_W-1:0]  prod_s3;
	logic signed [CALC_W-1:0] xoff_s3;

	assign m_sx = signed'({1'b0, m_s2});

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_s3 <= IDX_W'(py_s2 * m_sx);
			xoff_s3 <= flip_s2 ? (CALC_W'(m_sx) - px_s2 - CALC_W'(1)) : px_s2;
		end
	end

	// stage 4: strip index and bounds check
	logic signed [IDX_W-1:0] idx;
	logic [AW-1:0]           addr_s4;
	logic                    in_store_s4;

	assign idx = prod_s3 + IDX_W'(xoff_s3);

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			addr_s4     <= idx[AW-1:0];
			in_store_s4 <= !idx[IDX_W-1] &&
				(idx[IDX_W-2:0] < (IDX_W-1)'(NUM_PIXELS));
		end
	end

	// pixel memory, cleared after reset one entry a cycle
	logic [COLOR_W-1:0] mem [NUM_PIXELS];
	logic [COLOR_W-1:0] rd_data_q;
	logic [AW-1:0]      clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_step)
			clr_addr_q <= clr_addr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			mem[clr_addr_q] <= '0;
		else if (cmd.mem_go && wr_s1 && in_store_s4)
			mem[addr_s4] <= color_s1;
		if (cmd.mem_go)
			rd_data_q <= mem[addr_s4];
	end

	// output register
	logic [COLOR_W-1:0] read_color_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			read_color_q <= in_store_s4 ? rd_data_q : '0;
	end

	assign read_color       = read_color_q;
	assign status.clr_last  = (clr_addr_q == AW'(NUM_PIXELS - 1));
	assign status.item_read = rd_s1;

endmodule

### src/led_matrix_pixel_store_unit.sv
// Top level of the LED matrix pixel store: sequencer plus datapath.
// A read result shows on out_valid after the orient, multiply, index, memory
// and result steps (later if the previous result is still held). No new
// transfer is taken until the previous one has been through the four-step
// index sequence and the single-port pixel memory. Reset: config regs return
// to 16x16, orientation 0, serpentine on; a clearing pass blanks the store,
// with in_ready low until it ends (config writes are taken meanwhile).
module led_matrix_pixel_store_unit #(
	parameter int NUM_PIXELS = lmps_pkg::NUM_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [lmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmps_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	// access channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lmps_pkg::MODE_W-1:0]         mode,
	input  logic signed [lmps_pkg::COORD_W-1:0] x_coord,
	input  logic signed [lmps_pkg::COORD_W-1:0] y_coord,
	input  logic [lmps_pkg::COLOR_W-1:0]        pixel_color,
	// read result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lmps_pkg::COLOR_W-1:0]        read_color
);
	import lmps_pkg::*;

	// Command/status between sequencer and datapath.
	lmps_cmd_t    cmd;
	lmps_status_t status;

	// Sequencer: clearing pass, then per transfer:
	// accept -> orient -> multiply -> index/bounds -> memory -> (read) result.
	lmps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: wrap and clip on capture, mirror/swap, row*len + column
	// (reversed on odd rows when serpentine), bounds check, memory access.
	// Off-grid or out-of-store writes are dropped; out-of-store reads give 0.
	lmps_dpath #(
		.NUM_PIXELS (NUM_PIXELS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.mode        (mode),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.pixel_color (pixel_color),
		.read_color  (read_color),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
